// ===== design/msgd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgd_pkg
// Shared types, byte codes and the Morse lookup for the symbol group decoder.
// ----------------------------------------------------------------------------
package msgd_pkg;

  // Longest group accepted before the overlong error (range 1 to 6)
  localparam int unsigned MAX_GROUP_LEN = 6;

  localparam int unsigned PAT_W = 6;  // one bit per symbol, dash = 1
  localparam int unsigned LEN_W = 3;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_GROUP_LEN);

  localparam logic [7:0] SYM_DOT  = 8'd46;
  localparam logic [7:0] SYM_DASH = 8'd45;
  localparam logic [7:0] SYM_SEP  = 8'd124;
  localparam logic [7:0] SYM_SPC  = 8'd32;
  localparam logic [7:0] CHAR_ERR = 8'd33;

  typedef struct packed {
    logic [7:0] symbol_byte;
    logic       end_of_stream;
  } msgd_item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] decoded_char;
  } msgd_result_t;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_length;
    logic             group_invalid;
    logic             skipping_overlong;
  } msgd_status_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == SYM_SPC) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // Key is {length, pattern}; symbol k sits at pattern bit k.
  function automatic logic [7:0] morse_lookup(input logic [LEN_W-1:0] len,
                                              input logic [PAT_W-1:0] bits);
    logic [7:0] ch;
    ch = CHAR_ERR;
    case ({len, bits})
      {3'd1, 6'b000000}: ch = "E";
      {3'd2, 6'b000000}: ch = "I";
      {3'd3, 6'b000000}: ch = "S";
      {3'd4, 6'b000000}: ch = "H";
      {3'd5, 6'b000000}: ch = "5";
      {3'd5, 6'b010000}: ch = "4";
      {3'd4, 6'b001000}: ch = "V";
      {3'd5, 6'b011000}: ch = "3";
      {3'd3, 6'b000100}: ch = "U";
      {3'd4, 6'b000100}: ch = "F";
      {3'd6, 6'b001100}: ch = "?";
      {3'd5, 6'b011100}: ch = "2";
      {3'd2, 6'b000010}: ch = "A";
      {3'd3, 6'b000010}: ch = "R";
      {3'd4, 6'b000010}: ch = "L";
      {3'd6, 6'b101010}: ch = ".";
      {3'd3, 6'b000110}: ch = "W";
      {3'd4, 6'b000110}: ch = "P";
      {3'd4, 6'b001110}: ch = "J";
      {3'd5, 6'b011110}: ch = "1";
      {3'd6, 6'b011110}: ch = SYM_SPC;
      {3'd1, 6'b000001}: ch = "T";
      {3'd2, 6'b000001}: ch = "N";
      {3'd3, 6'b000001}: ch = "D";
      {3'd4, 6'b000001}: ch = "B";
      {3'd5, 6'b000001}: ch = "6";
      {3'd6, 6'b100001}: ch = "-";
      {3'd4, 6'b001001}: ch = "X";
      {3'd5, 6'b001001}: ch = "/";
      {3'd3, 6'b000101}: ch = "K";
      {3'd4, 6'b000101}: ch = "C";
      {3'd4, 6'b001101}: ch = "Y";
      {3'd2, 6'b000011}: ch = "M";
      {3'd3, 6'b000011}: ch = "G";
      {3'd4, 6'b000011}: ch = "Z";
      {3'd5, 6'b000011}: ch = "7";
      {3'd6, 6'b110011}: ch = ",";
      {3'd4, 6'b001011}: ch = "Q";
      {3'd3, 6'b000111}: ch = "O";
      {3'd5, 6'b000111}: ch = "8";
      {3'd6, 6'b000111}: ch = ":";
      {3'd5, 6'b001111}: ch = "9";
      {3'd5, 6'b011111}: ch = "0";
      default:           ch = CHAR_ERR;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/msgd_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgd_in_reg
// Input register: captures one request per cycle from the slave channel while it is empty or its request is taken.
// ----------------------------------------------------------------------------
module msgd_in_reg
  import msgd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol_byte
  input  logic       in_tlast,   // end_of_stream
  input  logic       take,       // downstream consumes the held request
  output logic       item_valid,
  output msgd_item_t item
);

  logic       valid_r, valid_nxt;
  msgd_item_t item_r;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload: load on every accepted request
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= '{symbol_byte: in_tdata, end_of_stream: in_tlast};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== design/msgd_group_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgd_group_core
// Group accumulator and table lookup: one request decoded per cycle while fire commits it.
// ----------------------------------------------------------------------------
module msgd_group_core
  import msgd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,     // commit the held request
  input  msgd_item_t   item,
  output msgd_result_t result,   // result the held request would give
  output msgd_status_t status
);

  logic [PAT_W-1:0] bits_r, bits_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             inv_r, inv_nxt;
  logic             skip_r, skip_nxt;

  always_comb begin
    bits_nxt = bits_r;
    len_nxt  = len_r;
    inv_nxt  = inv_r;
    skip_nxt = skip_r;
    result   = '{valid: 1'b0, decoded_char: CHAR_ERR};

    if (item.end_of_stream) begin
      result.valid = !skip_r && (len_r != '0);
      bits_nxt = '0;
      len_nxt  = '0;
      inv_nxt  = 1'b0;
      skip_nxt = 1'b0;
    end else if (is_blank(item.symbol_byte)) begin
      // drop whitespace
    end else if (skip_r) begin
      if (item.symbol_byte == SYM_SEP) begin
        skip_nxt = 1'b0;
      end
    end else if (item.symbol_byte == SYM_SEP) begin
      if (len_r != '0) begin
        result.valid        = 1'b1;
        result.decoded_char = inv_r ? CHAR_ERR : morse_lookup(len_r, bits_r);
      end
      bits_nxt = '0;
      len_nxt  = '0;
      inv_nxt  = 1'b0;
    end else if (len_r >= MAX_LEN) begin
      result.valid = 1'b1;
      bits_nxt = '0;
      len_nxt  = '0;
      inv_nxt  = 1'b0;
      skip_nxt = 1'b1;
    end else begin
      if (item.symbol_byte == SYM_DASH) begin
        for (int k = 0; k < PAT_W; k++) begin
          if (len_r == LEN_W'(k)) begin
            bits_nxt[k] = 1'b1;
          end
        end
      end else if (item.symbol_byte != SYM_DOT) begin
        inv_nxt = 1'b1;
      end
      len_nxt = len_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      len_r  <= '0;
      inv_r  <= 1'b0;
      skip_r <= 1'b0;
    end else if (fire) begin
      bits_r <= bits_nxt;
      len_r  <= len_nxt;
      inv_r  <= inv_nxt;
      skip_r <= skip_nxt;
    end
  end

  assign status = '{pattern_length: len_r, group_invalid: inv_r,
                    skipping_overlong: skip_r};

endmodule

// ===== design/msgd_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msgd_out_reg
// Result register: holds one decoded character for the master channel.
// ----------------------------------------------------------------------------
module msgd_out_reg
  import msgd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic [7:0] load_char,
  output logic       free,       // register can take a result this cycle
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [7:0] decoded_char
);

  logic       valid_r, valid_nxt;
  logic [7:0] char_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      char_r <= load_char;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = char_r;

endmodule

// ===== design/morse_symbol_group_decoder.sv =====
`timescale 1ns / 1ps
// Path: each request is held in the input register, decoded by the group core and
// its character held in the output register. Throughput: one input byte per cycle.
// Stalls come only from out_tready: a held result blocks just the requests
// that produce a result, others drain through the input register.
// Reset: synchronous rst_n low clears the group state and both valid flags.
// ----------------------------------------------------------------------------
// morse_symbol_group_decoder
// Streaming Morse decoder: collects dots and dashes up to a separator and
// emits the matching ASCII character, '!' on error, space for .----.
// ----------------------------------------------------------------------------
module morse_symbol_group_decoder
  import msgd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol_byte
  input  logic       in_tlast,   // end_of_stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [7:0] decoded_char
);

  logic         s1_valid;
  msgd_item_t   s1_item;
  msgd_result_t s1_result;
  msgd_status_t grp_status;
  logic         out_free;
  logic         s1_adv;

  // Advance the held request unless it has a result and the output is full
  assign s1_adv = s1_valid && (!s1_result.valid || out_free);

  // Capture requests from the slave side
  msgd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .take       (s1_adv),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  // Update the group and look up the closed pattern
  msgd_group_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_adv),
    .item   (s1_item),
    .result (s1_result),
    .status (grp_status)
  );

  // Hold the decoded character until the master side takes it
  msgd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_adv && s1_result.valid),
    .load_char  (s1_result.decoded_char),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Group never holds more symbols than allowed
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    grp_status.pattern_length <= MAX_LEN)
    else $error("group length above limit");

  // While skipping an overlong group nothing is collected
  a_skip_empty: assert property (@(posedge clk) disable iff (!rst_n)
    grp_status.skipping_overlong |->
      (grp_status.pattern_length == '0) && !grp_status.group_invalid)
    else $error("skipping with a pending group");

  // End of stream returns the group state to reset
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_item.end_of_stream) |=>
      (grp_status.pattern_length == '0) && !grp_status.skipping_overlong &&
      !grp_status.group_invalid)
    else $error("end of stream left group state");

  // Input back-pressure only with a request held
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid && s1_result.valid && out_tvalid && !out_tready))
    else $error("input stalled without cause");

endmodule

// ===== dv/morse_char_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_char_checker
// Watches both stream channels of the Morse decoder, predicts the characters
// that the accepted requests yield and compares them with the output stream.
// ----------------------------------------------------------------------------
module morse_char_checker
  import msgd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol_byte
  input  logic       in_tlast,   // end_of_stream
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] decoded_char
  output int         mismatch_count,
  output int         pending_chars
);

  localparam int unsigned KEY_W = LEN_W + PAT_W;

  // Code table, same order as the characters in MORSE_CHARS
  string morse_codes [43] = '{
    ".", "..", "...", "....", ".....", "....-", "...-", "...--", "..-",
    "..-.", "..--..", "..---", ".-", ".-.", ".-..", ".-.-.-", ".--",
    ".--.", ".---", ".----", ".----.", "-", "-.", "-..", "-...", "-....",
    "-....-", "-..-", "-..-.", "-.-", "-.-.", "-.--", "--", "--.",
    "--..", "--...", "--..--", "--.-", "---", "---..", "---...", "----.",
    "-----"
  };
  localparam string MORSE_CHARS = "EISH54V3UF?2ARL.WPJ1 TNDB6-X/KCYMGZ7,QO8:90";

  logic [7:0]       char_by_key [0:(1 << KEY_W) - 1];
  logic [7:0]       expected_chars [$];

  // Predicted group state
  logic [PAT_W-1:0] group_bits;
  logic [LEN_W-1:0] group_len;
  logic             group_bad;
  logic             skipping;

  initial begin : build_keys
    int e, k;
    logic [PAT_W-1:0] bits;
    for (e = 0; e < (1 << KEY_W); e++) char_by_key[e] = CHAR_ERR;
    for (e = 0; e < 43; e++) begin
      bits = '0;
      for (k = 0; k < morse_codes[e].len(); k++) begin
        if (morse_codes[e][k] == SYM_DASH) bits[k] = 1'b1;
      end
      char_by_key[{LEN_W'(morse_codes[e].len()), bits}] = MORSE_CHARS[e];
    end
    group_bits     = '0;
    group_len      = '0;
    group_bad      = 1'b0;
    skipping       = 1'b0;
    mismatch_count = 0;
    pending_chars  = 0;
  end

  task automatic clear_group();
    group_bits = '0;
    group_len  = '0;
    group_bad  = 1'b0;
  endtask

  // Advance the group state by one request; report the character it yields
  task automatic decode_symbol(input logic [7:0] b, input logic eos,
                               output bit has_char, output logic [7:0] ch);
    has_char = 1'b0;
    ch       = CHAR_ERR;
    if (eos) begin
      has_char = !skipping && (group_len != 0);
      clear_group();
      skipping = 1'b0;
    end else if (b == 8'd32 || (b >= 8'd9 && b <= 8'd13)) begin
      // whitespace: no effect at all
    end else if (skipping) begin
      if (b == SYM_SEP) skipping = 1'b0;
    end else if (b == SYM_SEP) begin
      if (group_len != 0) begin
        has_char = 1'b1;
        ch       = group_bad ? CHAR_ERR : char_by_key[{group_len, group_bits}];
      end
      clear_group();
    end else if (group_len >= MAX_LEN) begin
      clear_group();
      skipping = 1'b1;
      has_char = 1'b1;
    end else begin
      if (b == SYM_DASH) begin
        if (group_len < PAT_W) group_bits[group_len] = 1'b1;
      end else if (b != SYM_DOT) begin
        group_bad = 1'b1;
      end
      group_len = group_len + 1'b1;
    end
  endtask

  task automatic note_mismatch(input string what, input logic [7:0] exp_ch,
                               input logic [7:0] act_ch);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected 0x%02h, got 0x%02h", $realtime, what, exp_ch, act_ch);
  endtask

  always @(posedge clk) begin : monitor
    bit         has_char;
    logic [7:0] ch;
    logic [7:0] exp_ch;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          note_mismatch("unexpected decoded char", 8'h00, out_tdata);
        end else begin
          exp_ch = expected_chars.pop_front();
          if (out_tdata !== exp_ch) note_mismatch("decoded char", exp_ch, out_tdata);
        end
      end
      if (in_tvalid && in_tready) begin
        decode_symbol(in_tdata, in_tlast, has_char, ch);
        if (has_char) expected_chars.push_back(ch);
      end
      pending_chars <= expected_chars.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives character requests into the Morse symbol group decoder with bursty
// input and a stalling output, and lets the checker compare every decoded
// character against its own prediction.
// ----------------------------------------------------------------------------
module testbench;
  import msgd_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int ITEM_TARGET  = 400;   // counted requests in the random part
  localparam int LONG_HOLD    = 300;   // cycles of output back-pressure
  localparam int DRAIN_CYCLES = 20;    // quiet cycles after the last result
  localparam int RUN_LIMIT_NS = 4_000_000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] symbol_byte
  logic       in_tlast;   // end_of_stream
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] decoded_char

  int mismatch_count;
  int pending_chars;
  int items_sent;   // non-whitespace or end-of-stream requests accepted so far
  int burst_left;   // requests left in the current sender burst
  bit long_hold_req;

  always #(CLK_PERIOD / 2) clk = ~clk;

  morse_symbol_group_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  morse_char_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_chars  (pending_chars)
  );

  // Offer one request and hold it until the handshake completes. At the end
  // of a burst, drop valid for a random gap before the next burst starts.
  task automatic send_request(input logic [7:0] b, input logic eos);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (eos || !(b == 8'd32 || (b >= 8'd9 && b <= 8'd13))) items_sent++;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  // Random dots and dashes, with an occasional whitespace byte mixed in
  task automatic send_group(input int len, input bit with_blanks);
    int k;
    logic [7:0] blank;
    for (k = 0; k < len; k++) begin
      if (with_blanks && $urandom_range(0, 9) == 0) begin
        blank = 8'($urandom_range(8, 13));
        if (blank == 8'd8) blank = 8'd32;
        send_request(blank, 1'b0);
      end
      send_request($urandom_range(0, 1) ? SYM_DASH : SYM_DOT, 1'b0);
    end
  endtask

  // Receiver: stretches of random stall patterns, plus one long hold while
  // the sender keeps offering requests so that the decoder backs up.
  initial begin : receiver
    int mode, run, i;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        run  = $urandom_range(1, 24);
        for (i = 0; i < run; i++) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= ($urandom_range(0, 3) != 0);
            2:       out_tready <= 1'($urandom_range(0, 1));
            default: out_tready <= ($urandom_range(0, 4) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int kind, len;
    rst_n         <= 1'b0;
    in_tvalid     <= 1'b0;
    in_tdata      <= 8'h00;
    in_tlast      <= 1'b0;
    items_sent    = 0;
    burst_left    = 4;
    long_hold_req = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    send_request(8'hFF, 1'b1);        // end of stream with nothing pending
    send_text(".\t-|");               // A, with a tab inside the group
    send_text(" |");                  // blank, then an empty group
    send_text(".----.|");             // space code, longest legal group
    send_request(8'hFF, 1'b0);        // invalid bytes inside a group
    send_request(8'h00, 1'b0);
    send_request(SYM_SEP, 1'b0);
    send_text("---.|");               // well-formed but unknown group
    send_text(".----.-");             // overlong: error on the seventh symbol
    send_request(8'd13, 1'b0);        // blank while skipping
    send_request(8'h00, 1'b1);        // end of stream while skipping: nothing
    send_text("-");
    send_request(SYM_SEP, 1'b1);      // end of stream flushes, byte ignored

    // Random part; ask for the long output hold as it starts
    long_hold_req = 1'b1;
    items_sent    = 0;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // well-formed group, mostly short enough to hit the code table
        len = $urandom_range(1, 6);
        if (len > 4 && $urandom_range(0, 1)) len = $urandom_range(1, 4);
        send_group(len, 1'b1);
        send_request(SYM_SEP, 1'b0);
      end else if (kind < 70) begin
        // overlong group, some dropped bytes, then the closing separator
        send_group(MAX_GROUP_LEN + 1 + $urandom_range(0, 2), 1'b0);
        repeat ($urandom_range(0, 3)) send_request(8'($urandom_range(0, 255)), 1'b0);
        send_request(SYM_SEP, 1'b0);
      end else if (kind < 78) begin
        // group with a stray byte in it
        send_group($urandom_range(0, 3), 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b0);
        send_group($urandom_range(0, 2), 1'b0);
        send_request(SYM_SEP, 1'b0);
      end else if (kind < 83) begin
        send_request(SYM_SEP, 1'b0);
      end else if (kind < 90) begin
        // partial group cut off by end of stream
        send_group($urandom_range(0, 3), 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every expected character, then a few quiet cycles
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_chars == 0) begin
      $display("PASS morse_symbol_group_decoder");
    end else begin
      $display("FAIL morse_symbol_group_decoder");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("FAIL morse_symbol_group_decoder");
    $finish;
  end

endmodule

// ===== files.f =====
design/msgd_pkg.sv
design/msgd_in_reg.sv
design/msgd_group_core.sv
design/msgd_out_reg.sv
design/morse_symbol_group_decoder.sv
dv/morse_char_checker.sv
dv/testbench.sv
